>>> hw/rtl/eatrm_pkg.sv
`default_nettype none
package eatrm_pkg;
   localparam int CordicSteps = 16;
   localparam int CordicX0 = 163008219;
   localparam int OneQ14 = 16384;

   typedef logic signed [31:0] cordic_word_type;
   typedef logic signed [15:0] trig_type;

   typedef struct packed {
      trig_type c1;
      trig_type s1;
      trig_type c2;
      trig_type s2;
      trig_type c3;
      trig_type s3;
   } trig_set_type;

   // arctangent table in units of 2^-24 turn
   function automatic cordic_word_type atan_turns(input logic [3:0] idx);
      cordic_word_type r;
      unique case (idx)
         4'd0: r = 32'sd2097152;
         4'd1: r = 32'sd1238021;
         4'd2: r = 32'sd654136;
         4'd3: r = 32'sd332050;
         4'd4: r = 32'sd166669;
         4'd5: r = 32'sd83416;
         4'd6: r = 32'sd41718;
         4'd7: r = 32'sd20860;
         4'd8: r = 32'sd10430;
         4'd9: r = 32'sd5215;
         4'd10: r = 32'sd2608;
         4'd11: r = 32'sd1304;
         4'd12: r = 32'sd652;
         4'd13: r = 32'sd326;
         4'd14: r = 32'sd163;
         default: r = 32'sd81;
      endcase
      return r;
   endfunction

   // clamp a wide value to [-1.0, 1.0] in Q14
   function automatic trig_type clamp_one(input logic signed [47:0] v);
      trig_type r;
      if (v > 48'(OneQ14)) r = 16'(OneQ14);
      else if (v < -48'(OneQ14)) r = -16'(OneQ14);
      else r = v[15:0];
      return r;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/euler_angles_to_rotation_matrix.sv
// Euler angle to rotation matrix, R = Rz * Ry * Rx, fixed point.
// Input channel req_: three 16-bit binary angles (65536 = one turn), a beat
// is taken when req_valid is high and req_stall is low.
// Result channel rsp_: nine signed Q1.14 entries, 16384 meaning 1.0,
// saturated to +/-16384; a beat is taken when rsp_valid is high and
// rsp_stall is low.
// Throughput: one beat per cycle while the result channel is not stalled.
// Pipeline: 18 CORDIC stages, 3 product stages, 1 output register.
// The CORDIC and product pipeline set the depth; all three angles go
// through parallel CORDIC pipes.
// Reset clears every valid bit; payload registers are not reset.
// The whole pipeline holds, and req_stall is raised, only if the output
// register is full and the receiver stalls, so no beat is lost or
// repeated.
`default_nettype none
module euler_angles_to_rotation_matrix (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_angle_x,
   input  wire logic [15:0]        req_angle_y,
   input  wire logic [15:0]        req_angle_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_m00,
   output logic signed [15:0]      rsp_m01,
   output logic signed [15:0]      rsp_m02,
   output logic signed [15:0]      rsp_m10,
   output logic signed [15:0]      rsp_m11,
   output logic signed [15:0]      rsp_m12,
   output logic signed [15:0]      rsp_m20,
   output logic signed [15:0]      rsp_m21,
   output logic signed [15:0]      rsp_m22
);
   import eatrm_pkg::*;

   localparam int Depth = CordicSteps + 2 + 3;

   logic             enable;
   logic [Depth-1:0] vld_ff, vld_in;
   trig_set_type     trig;
   trig_type         m [9];
   trig_type         out_ff [9];
   logic             out_vld_ff, out_vld_in;

   // pipeline advances unless the output register is full and stalled
   assign enable    = !(out_vld_ff && rsp_stall);
   assign req_stall = !enable;

   eatrm_cordic u_cx (.clock(clock), .enable(enable), .angle(req_angle_x),
                      .cos_out(trig.c1), .sin_out(trig.s1));
   eatrm_cordic u_cy (.clock(clock), .enable(enable), .angle(req_angle_y),
                      .cos_out(trig.c2), .sin_out(trig.s2));
   eatrm_cordic u_cz (.clock(clock), .enable(enable), .angle(req_angle_z),
                      .cos_out(trig.c3), .sin_out(trig.s3));

   eatrm_matrix u_mat (.clock(clock), .enable(enable), .trig(trig), .m_out(m));

   // valid bits travel with the data
   always_comb begin
      vld_in     = {vld_ff[Depth-2:0], req_valid};
      out_vld_in = vld_ff[Depth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (enable) out_ff <= m;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_m00 = out_ff[0];
   assign rsp_m01 = out_ff[1];
   assign rsp_m02 = out_ff[2];
   assign rsp_m10 = out_ff[3];
   assign rsp_m11 = out_ff[4];
   assign rsp_m12 = out_ff[5];
   assign rsp_m20 = out_ff[6];
   assign rsp_m21 = out_ff[7];
   assign rsp_m22 = out_ff[8];

   // a stalled result holds its valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result valid dropped under stall");
   // input is stalled only when the output is full and stalled
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("spurious input stall");
   // an accepted beat reaches the pipe's first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted beat lost");
endmodule
`default_nettype wire

>>> hw/rtl/eatrm_cordic.sv
`default_nettype none
// Pipelined CORDIC with sixteen rotation stages giving cosine and sine of one binary angle.
// Stage count: 1 input register + 16 rotation stages + 1 rounding stage.
module eatrm_cordic (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [15:0]           angle,
   output eatrm_pkg::trig_type        cos_out,
   output eatrm_pkg::trig_type        sin_out
);
   import eatrm_pkg::*;

   cordic_word_type x_ff [CordicSteps+1];
   cordic_word_type y_ff [CordicSteps+1];
   cordic_word_type z_ff [CordicSteps+1];
   logic [1:0]      quad_ff [CordicSteps+1];
   trig_type        cos_ff, sin_ff;

   // seed stage
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= CordicX0;
         y_ff[0]    <= '0;
         z_ff[0]    <= {10'd0, angle[13:0], 8'd0};
         quad_ff[0] <= angle[15:14];
      end
   end

   // rotation stages, one micro-rotation each
   for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][31]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turns(4'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turns(4'(i));
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // round to Q14, clamp and unfold the quadrant
   trig_type cq, sq;
   always_comb begin
      cq = clamp_one(48'(($signed({x_ff[CordicSteps][31], x_ff[CordicSteps]}) + 33'sd8192)
                         >>> 14));
      sq = clamp_one(48'(($signed({y_ff[CordicSteps][31], y_ff[CordicSteps]}) + 33'sd8192)
                         >>> 14));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unique case (quad_ff[CordicSteps])
            2'd0: begin cos_ff <= cq;  sin_ff <= sq;  end
            2'd1: begin cos_ff <= -sq; sin_ff <= cq;  end
            2'd2: begin cos_ff <= -cq; sin_ff <= -sq; end
            default: begin cos_ff <= sq; sin_ff <= -cq; end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule
`default_nettype wire

>>> hw/rtl/eatrm_matrix.sv
`default_nettype none
// Product pipeline: pair products, then triple products and sums, then rounding.
module eatrm_matrix (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  eatrm_pkg::trig_set_type      trig,
   output eatrm_pkg::trig_type          m_out [9]
);
   import eatrm_pkg::*;

   typedef logic signed [31:0] prod2_type;
   typedef logic signed [47:0] prod3_type;

   // stage 1: two-factor products
   prod2_type s1s2_ff, c1s2_ff, c2c3_ff, c2s3_ff, c1s3_ff, s1s3_ff;
   prod2_type c1c3_ff, s1c3_ff, s1c2_ff, c1c2_ff;
   trig_type  c3_ff, s3_ff, ns2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s1s2_ff <= trig.s1 * trig.s2;
         c1s2_ff <= trig.c1 * trig.s2;
         c2c3_ff <= trig.c2 * trig.c3;
         c2s3_ff <= trig.c2 * trig.s3;
         c1s3_ff <= trig.c1 * trig.s3;
         s1s3_ff <= trig.s1 * trig.s3;
         c1c3_ff <= trig.c1 * trig.c3;
         s1c3_ff <= trig.s1 * trig.c3;
         s1c2_ff <= trig.s1 * trig.c2;
         c1c2_ff <= trig.c1 * trig.c2;
         c3_ff   <= trig.c3;
         s3_ff   <= trig.s3;
         ns2_ff  <= clamp_one(-48'(trig.s2));
      end
   end

   // stage 2: third factor (by the angle-z term or by 2^14) and sums at Q42; entry 6 (-s2) stays Q14
   prod3_type acc_ff [9];
   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff[0] <= 48'(c2c3_ff) <<< 14;
         acc_ff[1] <= 48'(s1s2_ff) * 48'(c3_ff) - (48'(c1s3_ff) <<< 14);
         acc_ff[2] <= 48'(c1s2_ff) * 48'(c3_ff) + (48'(s1s3_ff) <<< 14);
         acc_ff[3] <= 48'(c2s3_ff) <<< 14;
         acc_ff[4] <= 48'(s1s2_ff) * 48'(s3_ff) + (48'(c1c3_ff) <<< 14);
         acc_ff[5] <= 48'(c1s2_ff) * 48'(s3_ff) - (48'(s1c3_ff) <<< 14);
         acc_ff[6] <= 48'(ns2_ff);
         acc_ff[7] <= 48'(s1c2_ff) <<< 14;
         acc_ff[8] <= 48'(c1c2_ff) <<< 14;
      end
   end

   // stage 3: round half up to Q14 and saturate, except entry 6, which passes through
   trig_type m_ff [9];
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < 9; j++) begin
            if (j == 6) m_ff[j] <= acc_ff[j][15:0];
            else m_ff[j] <= clamp_one((acc_ff[j] + 48'sd134217728) >>> 28);
         end
      end
   end

   assign m_out = m_ff;
endmodule
`default_nettype wire
